@@ sv/rfmd_pkg.sv @@
`default_nettype none

package rfmd_pkg;

  localparam int CNT_W = 32;
  localparam int NUM_DIGITS = 5;
  localparam int SUM_W = 48;
  localparam int FREQ_W = 20;
  localparam int CLK_W = 27;
  localparam int PERIOD_MIN_W = 16;
  localparam int CLAMP_W = 17;
  localparam int TICK_W = 16;
  localparam int DIV_REM_W = 32;
  localparam int DIV_STEPS_W = $clog2(SUM_W + 1);
  localparam int DIGIT_IDX_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HZ      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FREQ      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FREQ      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_CLAMP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 3'd6;

  localparam logic [0:0] CMD_CAPTURE = 1'b0;
  localparam logic [0:0] CMD_TICK    = 1'b1;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_DIFF   = 9'b000000010,
    ST_CDIV   = 9'b000000100,
    ST_ACCUM  = 9'b000001000,
    ST_TOUT   = 9'b000010000,
    ST_WDIV   = 9'b000100000,
    ST_BLOAD  = 9'b001000000,
    ST_BCD    = 9'b010000000,
    ST_FINISH = 9'b100000000
  } state_t;

  // active-high segment pattern, bit0 = A; anything above nine shows zero
  function automatic logic [6:0] seg_decode(input logic [3:0] val);
    logic [6:0] pat;
    case (val)
      4'd0: pat = 7'h3F;
      4'd1: pat = 7'h06;
      4'd2: pat = 7'h5B;
      4'd3: pat = 7'h4F;
      4'd4: pat = 7'h66;
      4'd5: pat = 7'h6D;
      4'd6: pat = 7'h7D;
      4'd7: pat = 7'h07;
      4'd8: pat = 7'h7F;
      4'd9: pat = 7'h6F;
      default: pat = 7'h3F;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

@@ sv/rfmd_div.sv @@
`default_nettype none

module rfmd_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [rfmd_pkg::SUM_W-1:0]     dividend,
  input  wire logic [rfmd_pkg::DIV_REM_W-1:0] divisor,
  input  wire logic [rfmd_pkg::DIV_STEPS_W-1:0] steps,
  output logic                                done,
  output logic [rfmd_pkg::SUM_W-1:0]          quotient
);
  import rfmd_pkg::*;

  logic                   busy;
  logic [DIV_STEPS_W-1:0] cnt;
  logic [DIV_REM_W-1:0]   rem;
  logic [DIV_REM_W-1:0]   dvs;
  logic [SUM_W-1:0]       acc;

  logic [DIV_REM_W:0] shifted;
  logic [DIV_REM_W:0] trial;
  logic               qbit;

  // one quotient bit per cycle, restoring
  always_comb begin
    shifted = {rem, acc[SUM_W-1]};
    trial   = shifted - {1'b0, dvs};
    qbit    = (shifted >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_STEPS_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      acc <= dividend;
    end else if (busy) begin
      rem <= qbit ? trial[DIV_REM_W-1:0] : shifted[DIV_REM_W-1:0];
      acc <= {acc[SUM_W-2:0], qbit};
    end
  end

  assign quotient = acc;

endmodule

`default_nettype wire

@@ sv/reciprocal_frequency_meter_display.sv @@
// capture event: result follows the difference, serial divide (27 quotient bits) and accumulate states
// capture whose period is at or below min_period: result follows the difference state, with no divide
// refresh tick inside a window: goes straight to the finish state, with no divide
// window-closing tick: 48-bit divide, then 17-bit bcd conversion; no divide on timeout or an empty window
// one transaction in work at a time; a new one is taken while the last result waits
// synchronous active-high reset restores register defaults and clears sums, digits, scan
`default_nettype none

module reciprocal_frequency_meter_display (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            cmd,
  input  wire logic [31:0]                     capture_time,
  input  wire logic [31:0]                     counter_now,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 sample_accepted,
  output logic [rfmd_pkg::DIGIT_IDX_W-1:0]     digit_index,
  output logic [6:0]                           segments,
  output logic                                 window_done,
  output logic [rfmd_pkg::FREQ_W-1:0]          average_freq,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [rfmd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rfmd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rfmd_pkg::*;

  // configuration
  logic [CLK_W-1:0]        clock_hz;
  logic [PERIOD_MIN_W-1:0] min_period;
  logic [FREQ_W-1:0]       min_freq;
  logic [FREQ_W-1:0]       max_freq;
  logic [CLAMP_W-1:0]      display_clamp;
  logic [TICK_W-1:0]       window_ticks;
  logic [CNT_W-1:0]        timeout_ticks;

  // block state
  state_t                 state;
  logic [CNT_W-1:0]       last_edge_time;
  logic [SUM_W-1:0]       window_sum;
  logic [CNT_W-1:0]       window_count;
  logic [FREQ_W-1:0]      shown_freq;
  logic [3:0]             digit_values [NUM_DIGITS];
  logic [DIGIT_IDX_W-1:0] scan_position;
  logic [TICK_W-1:0]      tick_count;

  // working registers
  logic [CNT_W-1:0]       stamp;
  logic                   res_accepted;
  logic [DIGIT_IDX_W-1:0] res_index;
  logic [6:0]             res_segments;
  logic                   res_done;
  logic [CLAMP_W-1:0]     bin_sr;
  logic [4*NUM_DIGITS-1:0] bcd;
  logic [4:0]             bcd_cnt;

  // divider hookup
  logic                   div_start;
  logic [SUM_W-1:0]       div_dividend;
  logic [DIV_REM_W-1:0]   div_divisor;
  logic [DIV_STEPS_W-1:0] div_steps;
  logic                   div_done;
  logic [SUM_W-1:0]       div_quot;

  logic                   in_take;
  logic                   out_free;
  logic [TICK_W-1:0]      tick_next;
  logic [CNT_W-1:0]       stamp_dist;
  logic [CLK_W-1:0]       sample_f;
  logic [SUM_W:0]         sum_add;
  logic                   sample_ok;
  logic [CLAMP_W-1:0]     clamped;
  logic [4*NUM_DIGITS-1:0] bcd_adj;
  logic [4*NUM_DIGITS-1:0] bcd_shift;

  assign in_stall  = (state != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  rfmd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    tick_next  = tick_count + TICK_W'(1);
    // the same subtractor serves the period and the timeout distance
    stamp_dist = stamp - last_edge_time;
    sample_f   = div_quot[CLK_W-1:0];
    sum_add    = {1'b0, window_sum} + (SUM_W + 1)'(sample_f);
    sample_ok  = (sample_f >= CLK_W'(min_freq)) && (sample_f <= CLK_W'(max_freq)) &&
                 (window_count != '1) && !sum_add[SUM_W];
    clamped    = (shown_freq > FREQ_W'(display_clamp)) ? display_clamp
                                                          : shown_freq[CLAMP_W-1:0];
    for (int k = 0; k < NUM_DIGITS; k++) begin
      bcd_adj[4*k +: 4] = (bcd[4*k +: 4] >= 4'd5) ? bcd[4*k +: 4] + 4'd3 : bcd[4*k +: 4];
    end
    // top carry is the hundred-thousands bit and is dropped, so the top digit wraps
    bcd_shift = {bcd_adj[4*NUM_DIGITS-2:0], bin_sr[CLAMP_W-1]};
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = {clock_hz, {(SUM_W - CLK_W){1'b0}}};
    div_divisor  = stamp_dist;
    div_steps    = DIV_STEPS_W'(CLK_W);
    case (state)
      ST_DIFF: begin
        div_start = (stamp_dist > CNT_W'(min_period));
      end
      ST_TOUT: begin
        div_dividend = window_sum;
        div_divisor  = window_count;
        div_steps    = DIV_STEPS_W'(SUM_W);
        div_start    = !(stamp_dist > timeout_ticks) && (window_count != '0);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz      <= CLK_W'(16000000);
      min_period    <= PERIOD_MIN_W'(150);
      min_freq      <= FREQ_W'(1000);
      max_freq      <= FREQ_W'(55000);
      display_clamp <= CLAMP_W'(50000);
      window_ticks  <= TICK_W'(500);
      timeout_ticks <= CNT_W'(16000000);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CLOCK_HZ:      clock_hz      <= cfg_data[CLK_W-1:0];
        REG_MIN_PERIOD:    min_period    <= cfg_data[PERIOD_MIN_W-1:0];
        REG_MIN_FREQ:      min_freq      <= cfg_data[FREQ_W-1:0];
        REG_MAX_FREQ:      max_freq      <= cfg_data[FREQ_W-1:0];
        REG_DISPLAY_CLAMP: display_clamp <= cfg_data[CLAMP_W-1:0];
        REG_WINDOW_TICKS:  window_ticks  <= cfg_data[TICK_W-1:0];
        REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      last_edge_time <= '0;
      window_sum     <= '0;
      window_count   <= '0;
      shown_freq     <= '0;
      scan_position  <= '0;
      tick_count     <= '0;
      out_valid      <= 1'b0;
      for (int k = 0; k < NUM_DIGITS; k++) begin
        digit_values[k] <= '0;
      end
    end else begin
      if (out_valid && !out_stall && (state != ST_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            if (cmd == CMD_TICK) begin
              if (scan_position == DIGIT_IDX_W'(NUM_DIGITS - 1)) begin
                scan_position <= '0;
              end else begin
                scan_position <= scan_position + 1'b1;
              end
              if (tick_next >= window_ticks) begin
                tick_count <= '0;
                state      <= ST_TOUT;
              end else begin
                tick_count <= tick_next;
                state      <= ST_FINISH;
              end
            end else begin
              state <= ST_DIFF;
            end
          end
        end
        ST_DIFF: begin
          last_edge_time <= stamp;
          state <= div_start ? ST_CDIV : ST_FINISH;
        end
        ST_CDIV: begin
          if (div_done) begin
            state <= ST_ACCUM;
          end
        end
        ST_ACCUM: begin
          if (sample_ok) begin
            window_sum   <= sum_add[SUM_W-1:0];
            window_count <= window_count + 1'b1;
          end
          state <= ST_FINISH;
        end
        ST_TOUT: begin
          if (div_start) begin
            state <= ST_WDIV;
          end else begin
            if (stamp_dist > timeout_ticks) begin
              shown_freq <= '0;
            end
            window_sum   <= '0;
            window_count <= '0;
            state        <= ST_BLOAD;
          end
        end
        ST_WDIV: begin
          if (div_done) begin
            shown_freq   <= div_quot[FREQ_W-1:0];
            window_sum   <= '0;
            window_count <= '0;
            state        <= ST_BLOAD;
          end
        end
        ST_BLOAD: begin
          state <= ST_BCD;
        end
        ST_BCD: begin
          if (bcd_cnt == 5'(CLAMP_W - 1)) begin
            for (int k = 0; k < NUM_DIGITS; k++) begin
              digit_values[NUM_DIGITS-1-k] <= bcd_shift[4*k +: 4];
            end
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      stamp        <= (cmd == CMD_TICK) ? counter_now[CNT_W-1:0] : capture_time[CNT_W-1:0];
      res_accepted <= 1'b0;
      res_index    <= (cmd == CMD_TICK) ? scan_position : '0;
      res_segments <= (cmd == CMD_TICK) ? seg_decode(digit_values[scan_position]) : '0;
      res_done     <= (cmd == CMD_TICK) && (tick_next >= window_ticks);
    end
    if (state == ST_ACCUM) begin
      res_accepted <= sample_ok;
    end
    if (state == ST_BLOAD) begin
      bin_sr  <= clamped;
      bcd     <= '0;
      bcd_cnt <= '0;
    end
    if (state == ST_BCD) begin
      bin_sr  <= {bin_sr[CLAMP_W-2:0], 1'b0};
      bcd     <= bcd_shift;
      bcd_cnt <= bcd_cnt + 1'b1;
    end
    if (state == ST_FINISH && out_free) begin
      sample_accepted <= res_accepted;
      digit_index     <= res_index;
      segments        <= res_segments;
      window_done     <= res_done;
      average_freq    <= shown_freq;
    end
  end

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    scan_position < DIGIT_IDX_W'(NUM_DIGITS))
    else $error("scan position out of range");

  a_window_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) && res_done |-> (window_count == '0) && (window_sum == '0))
    else $error("window not cleared on close");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACCUM) && sample_ok |=> window_count == $past(window_count) + 1'b1)
    else $error("window count did not advance on accepted sample");

  a_digit_bcd: assert property (@(posedge clk) disable iff (rst)
    (digit_values[0] <= 4'd9) && (digit_values[1] <= 4'd9) && (digit_values[2] <= 4'd9) &&
    (digit_values[3] <= 4'd9) && (digit_values[4] <= 4'd9))
    else $error("digit value above nine");

endmodule

`default_nettype wire

@@ tb/meter_monitor.sv @@
`timescale 1ns / 1ps

module meter_monitor (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            cmd,
  input  logic [31:0]                     capture_time,
  input  logic [31:0]                     counter_now,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic                            sample_accepted,
  input  logic [rfmd_pkg::DIGIT_IDX_W-1:0] digit_index,
  input  logic [6:0]                      segments,
  input  logic                            window_done,
  input  logic [rfmd_pkg::FREQ_W-1:0]     average_freq,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [rfmd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rfmd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              pending
);
  import rfmd_pkg::*;

  typedef struct packed {
    logic                   accepted;
    logic [DIGIT_IDX_W-1:0] idx;
    logic [6:0]             segs;
    logic                   done;
    logic [FREQ_W-1:0]      avg;
  } reading_t;

  localparam logic [63:0] SUM_LIMIT = 64'h0000_FFFF_FFFF_FFFF;

  reading_t readings_due[$];
  reading_t want;

  // register copies
  logic [26:0] hz;
  logic [15:0] noise_floor;
  logic [19:0] f_lo;
  logic [19:0] f_hi;
  logic [16:0] clamp;
  logic [15:0] win_len;
  logic [31:0] lost_after;

  // meter state
  logic [31:0] last_edge;
  logic [47:0] sum;
  logic [31:0] cnt;
  logic [19:0] shown;
  logic [3:0]  digs [NUM_DIGITS];
  logic [2:0]  scan;
  logic [15:0] ticks;

  function automatic logic [6:0] digit_pattern(input logic [3:0] d);
    logic [6:0] p;
    case (d)
      4'd1: p = 7'h06;
      4'd2: p = 7'h5B;
      4'd3: p = 7'h4F;
      4'd4: p = 7'h66;
      4'd5: p = 7'h6D;
      4'd6: p = 7'h7D;
      4'd7: p = 7'h07;
      4'd8: p = 7'h7F;
      4'd9: p = 7'h6F;
      default: p = 7'h3F;
    endcase
    return p;
  endfunction

  task automatic meter_step(input logic c, input logic [31:0] stamp, input logic [31:0] now_cnt,
                            output reading_t r);
    logic [31:0] period;
    logic [31:0] span;
    logic [63:0] f;
    logic [63:0] avg;
    logic [16:0] v;
    int k;
    r = '0;
    if (c == CMD_CAPTURE) begin
      period = stamp - last_edge;
      last_edge = stamp;
      if (period > noise_floor && period != 0) begin
        f = {37'b0, hz} / {32'b0, period};
        if (f >= f_lo && f <= f_hi && cnt != 32'hFFFF_FFFF && f <= SUM_LIMIT - {16'b0, sum}) begin
          sum = sum + f[47:0];
          cnt = cnt + 1;
          r.accepted = 1'b1;
        end
      end
    end else begin
      if (scan >= NUM_DIGITS) scan = 0;
      r.segs = digit_pattern(digs[scan]);
      r.idx = scan;
      scan = (scan == NUM_DIGITS - 1) ? 3'd0 : scan + 3'd1;
      ticks = ticks + 16'd1;
      if (ticks >= win_len) begin
        span = now_cnt - last_edge;
        ticks = 0;
        if (span > lost_after) begin
          shown = 0;
        end else if (cnt != 0) begin
          avg = {16'b0, sum} / {32'b0, cnt};
          shown = avg[19:0];
        end
        sum = 0;
        cnt = 0;
        // clamp only limits what the digits show
        v = (shown > clamp) ? clamp : shown[16:0];
        for (k = NUM_DIGITS - 1; k >= 0; k--) begin
          digs[k] = 4'(v % 10);
          v = v / 10;
        end
        r.done = 1'b1;
      end
    end
    r.avg = shown;
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_val);
    $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      hz = 27'd16000000;
      noise_floor = 16'd150;
      f_lo = 20'd1000;
      f_hi = 20'd55000;
      clamp = 17'd50000;
      win_len = 16'd500;
      lost_after = 32'd16000000;
      last_edge = 0;
      sum = 0;
      cnt = 0;
      shown = 0;
      for (int k = 0; k < NUM_DIGITS; k++) digs[k] = 0;
      scan = 0;
      ticks = 0;
      readings_due.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CLOCK_HZ:      hz = cfg_data[26:0];
          REG_MIN_PERIOD:    noise_floor = cfg_data[15:0];
          REG_MIN_FREQ:      f_lo = cfg_data[19:0];
          REG_MAX_FREQ:      f_hi = cfg_data[19:0];
          REG_DISPLAY_CLAMP: clamp = cfg_data[16:0];
          REG_WINDOW_TICKS:  win_len = cfg_data[15:0];
          REG_TIMEOUT_TICKS: lost_after = cfg_data;
          default: ;
        endcase
      end
      // results leave before this edge's transaction is predicted
      if (out_valid && !out_stall) begin
        if (readings_due.size() == 0) begin
          report("unexpected result", average_freq, 0);
        end else begin
          want = readings_due.pop_front();
          if (sample_accepted !== want.accepted)
            report("sample_accepted", sample_accepted, want.accepted);
          if (digit_index !== want.idx) report("digit_index", digit_index, want.idx);
          if (segments !== want.segs) report("segments", segments, want.segs);
          if (window_done !== want.done) report("window_done", window_done, want.done);
          if (average_freq !== want.avg) report("average_freq", average_freq, want.avg);
        end
      end
      if (in_valid && !in_stall) begin
        meter_step(cmd, capture_time, counter_now, want);
        readings_due.push_back(want);
      end
    end
    pending = readings_due.size();
  end

endmodule

@@ tb/reciprocal_frequency_meter_display_test.sv @@
`timescale 1ns / 1ps

module reciprocal_frequency_meter_display_test;
  import rfmd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
  localparam int IDLE_LIMIT = 2000;

  typedef struct {
    logic [31:0] hz;
    logic [31:0] noise;
    logic [31:0] f_lo;
    logic [31:0] f_hi;
    logic [31:0] clamp;
    logic [31:0] win;
    logic [31:0] lost;
  } meter_setup_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic                  cmd;
  logic [31:0]           capture_time;
  logic [31:0]           counter_now;
  logic                  out_valid;
  logic                  out_stall;
  logic                  sample_accepted;
  logic [DIGIT_IDX_W-1:0] digit_index;
  logic [6:0]            segments;
  logic                  window_done;
  logic [FREQ_W-1:0]     average_freq;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int           mismatches;
  int           pending;
  int           idle_cycles;
  bit           calm;
  meter_setup_t now_setup;
  logic [31:0]  stamp;

  reciprocal_frequency_meter_display uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .capture_time(capture_time),
    .counter_now(counter_now),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sample_accepted(sample_accepted),
    .digit_index(digit_index),
    .segments(segments),
    .window_done(window_done),
    .average_freq(average_freq),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  meter_monitor watch (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .capture_time(capture_time),
    .counter_now(counter_now),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sample_accepted(sample_accepted),
    .digit_index(digit_index),
    .segments(segments),
    .window_done(window_done),
    .average_freq(average_freq),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatches(mismatches),
    .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("reciprocal_frequency_meter_display_test failed");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    int hold;
    out_stall = 0;
    wait (!rst);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 14);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic send_item(input logic c, input logic [31:0] ct, input logic [31:0] cn);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    capture_time <= ct;
    counter_now <= cn;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic capture(input logic [31:0] t);
    send_item(CMD_CAPTURE, t, $urandom);
    stamp = t;
  endtask

  task automatic tick(input logic [31:0] cn);
    send_item(CMD_TICK, $urandom, cn);
  endtask

  // drain every outstanding transaction before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_setup(input meter_setup_t s);
    write_reg(REG_CLOCK_HZ, s.hz);
    write_reg(REG_MIN_PERIOD, s.noise);
    write_reg(REG_MIN_FREQ, s.f_lo);
    write_reg(REG_MAX_FREQ, s.f_hi);
    write_reg(REG_DISPLAY_CLAMP, s.clamp);
    write_reg(REG_WINDOW_TICKS, s.win);
    write_reg(REG_TIMEOUT_TICKS, s.lost);
    write_reg(REG_NONE, $urandom);
    cfg_valid <= 1'b0;
    now_setup = s;
  endtask

  function automatic meter_setup_t phase_setup(input int k);
    meter_setup_t s;
    case (k)
      0: s = '{32'd16000000, 32'd150, 32'd1000, 32'd55000, 32'd50000, 32'd5, 32'd16000000};
      1: s = '{32'd100000000, 32'd65535, 32'd0, 32'd1000000, 32'd99999, 32'd3, 32'hFFFF_FFFF};
      2: s = '{32'd1, 32'd0, 32'd0, 32'd1, 32'd0, 32'd1, 32'd0};
      3: s = '{32'd1000000, 32'd0, 32'd0, 32'h000F_FFFF, 32'd131071, 32'd0, 32'd1000};
      5: s = '{32'd0, 32'd0, 32'd0, 32'd1000, 32'd300, 32'd2, 32'd5000};
      default: begin
        s.hz = $urandom_range(1000, 100000000);
        s.noise = $urandom_range(0, 500);
        s.f_lo = $urandom_range(0, 5000);
        s.f_hi = $urandom_range(s.f_lo, 1000000);
        s.clamp = $urandom_range(0, 99999);
        s.win = (k == 4) ? 32'd65535 : $urandom_range(1, 12);
        s.lost = $urandom_range(1000, 32'hFFFF_FFFF);
      end
    endcase
    return s;
  endfunction

  // period that lands inside the accepted frequency band
  function automatic logic [31:0] in_band_period();
    logic [63:0] lo;
    logic [63:0] hi;
    lo = {32'b0, now_setup.hz} / ({32'b0, now_setup.f_hi} + 64'd1) + 64'd1;
    if (lo <= now_setup.noise) lo = {32'b0, now_setup.noise} + 64'd1;
    if (now_setup.f_lo == 0) begin
      hi = lo + 64'd4000;
    end else begin
      hi = {32'b0, now_setup.hz} / {32'b0, now_setup.f_lo};
    end
    if (hi < lo) hi = lo;
    return 32'(lo + ({32'b0, $urandom} % (hi - lo + 64'd1)));
  endfunction

  task automatic random_item();
    int r;
    logic [31:0] cn;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      capture(stamp + in_band_period());
    end else if (r < 50) begin
      capture(stamp + $urandom_range(0, now_setup.noise));
    end else if (r < 55) begin
      capture($urandom);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        cn = $urandom;
      end else if (r < 25) begin
        cn = stamp + now_setup.lost + 32'd1 + $urandom_range(0, 50);
      end else begin
        cn = stamp + $urandom_range(0, 200);
      end
      tick(cn);
    end
  endtask

  initial begin
    meter_setup_t s;
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = CMD_CAPTURE;
    capture_time = 0;
    counter_now = 0;
    cfg_valid = 1'b0;
    cfg_index = REG_CLOCK_HZ;
    cfg_data = 0;
    calm = 0;
    stamp = 0;
    now_setup = phase_setup(0);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: blank digits, zero and near full-range periods
    tick(32'd0);
    tick(32'hFFFF_FFFF);
    capture(32'd0);
    capture(32'd1000);
    capture(32'hFFFF_FFFF);
    settle();

    // full-scale samples, clamp above five digits, short window
    s = '{32'd1000000, 32'd0, 32'd0, 32'h000F_FFFF, 32'd131071, 32'd2, 32'd100};
    load_setup(s);
    capture(32'd5);
    capture(32'd6);
    tick(32'd10);
    tick(32'd10);
    tick(32'd10);
    tick(32'd10);
    tick(32'd10);
    tick(32'd20);
    tick(32'd20);
    tick(32'd300);
    tick(32'd300);
    tick(32'd300);
    settle();

    for (int k = 0; k < 8; k++) begin
      s = phase_setup(k);
      load_setup(s);
      calm = (k == 2 || k == 5);
      repeat (80) random_item();
      settle();
    end
    calm = 0;

    repeat (150) @(posedge clk);
    if (mismatches == 0) begin
      $display("reciprocal_frequency_meter_display_test passed");
    end else begin
      $display("reciprocal_frequency_meter_display_test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/rfmd_pkg.sv
sv/rfmd_div.sv
sv/reciprocal_frequency_meter_display.sv
tb/meter_monitor.sv
tb/reciprocal_frequency_meter_display_test.sv
